>>> sv/blpg_pkg.sv
// ----------------------------------------------------------------------------
// blpg_pkg: shared types and helpers for the line pixel generator
// Coordinate widths, direction codes, the decoded command word passed from
// the front end to the drawing back end, and the cursor step function.
// ----------------------------------------------------------------------------
package blpg_pkg;

  localparam int COORD_BITS = 10;
  localparam int COLOUR_W   = 8;
  localparam int CNT_W      = COORD_BITS + 1;
  localparam int ERR_W      = COORD_BITS + 3;
  localparam int DIR_W      = 2;
  localparam int Q_DEPTH    = 2;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int Q_CNT_W    = Q_PTR_W + 1;

  typedef logic [COORD_BITS-1:0]   coord_t;
  typedef logic [COLOUR_W-1:0]     colour_t;
  typedef logic [CNT_W-1:0]        cnt_t;
  typedef logic signed [ERR_W-1:0] err_t;
  typedef logic [DIR_W-1:0]        dir_t;

  localparam logic ACT_START = 1'b0;
  localparam logic ACT_STEP  = 1'b1;

  localparam dir_t DIR_NONE = 2'd0;
  localparam dir_t DIR_POS  = 2'd1;
  localparam dir_t DIR_NEG  = 2'd3;

  typedef struct packed {
    logic    is_start;
    coord_t  x;
    coord_t  y;
    colour_t colour;
    logic    steep;
    coord_t  major;
    coord_t  minor;
    err_t    err;
    dir_t    dir_x;
    dir_t    dir_y;
  } blpg_cmd_t;

  function automatic coord_t move_coord(input coord_t c, input dir_t dir);
    coord_t res;
    unique case (dir)
      DIR_POS: res = c + coord_t'(1);
      DIR_NEG: res = c - coord_t'(1);
      default: res = c;
    endcase
    return res;
  endfunction

endpackage

>>> sv/blpg_front.sv
// ----------------------------------------------------------------------------
// blpg_front: command classifier and line setup
// Decodes each input beat into a start or step command. For a start it
// computes the axis deltas and directions, the steep flag, the major and
// minor deltas and the initial error term.
// ----------------------------------------------------------------------------
module blpg_front import blpg_pkg::*; (
  input  logic      in_action,
  input  coord_t    in_x_begin,
  input  coord_t    in_y_begin,
  input  coord_t    in_x_finish,
  input  coord_t    in_y_finish,
  input  colour_t   in_pen_colour,
  output blpg_cmd_t cmd
);

  coord_t dx;
  coord_t dy;
  dir_t   dir_x;
  dir_t   dir_y;
  logic   steep;
  coord_t major;
  coord_t minor;

  always_comb begin
    if (in_x_finish > in_x_begin) begin
      dx    = in_x_finish - in_x_begin;
      dir_x = DIR_POS;
    end else if (in_x_finish < in_x_begin) begin
      dx    = in_x_begin - in_x_finish;
      dir_x = DIR_NEG;
    end else begin
      dx    = '0;
      dir_x = DIR_NONE;
    end
    if (in_y_finish > in_y_begin) begin
      dy    = in_y_finish - in_y_begin;
      dir_y = DIR_POS;
    end else if (in_y_finish < in_y_begin) begin
      dy    = in_y_begin - in_y_finish;
      dir_y = DIR_NEG;
    end else begin
      dy    = '0;
      dir_y = DIR_NONE;
    end
    steep = dy > dx;
    major = steep ? dy : dx;
    minor = steep ? dx : dy;
  end

  always_comb begin
    cmd.is_start = (in_action == ACT_START);
    cmd.x        = in_x_begin;
    cmd.y        = in_y_begin;
    cmd.colour   = in_pen_colour;
    cmd.steep    = steep;
    cmd.major    = major;
    cmd.minor    = minor;
    cmd.err      = $signed({2'b00, minor, 1'b0}) - $signed({3'b000, major});
    cmd.dir_x    = dir_x;
    cmd.dir_y    = dir_y;
  end

endmodule

>>> sv/blpg_cmd_queue.sv
// ----------------------------------------------------------------------------
// blpg_cmd_queue: command queue between front end and back end
// A small first-in first-out buffer of decoded commands so that the input
// side and the pixel side can stall independently.
// ----------------------------------------------------------------------------
module blpg_cmd_queue import blpg_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  blpg_cmd_t push_cmd,
  output logic      full,
  input  logic      pop,
  output logic      not_empty,
  output blpg_cmd_t head_cmd
);

  blpg_cmd_t            entry_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]   count_r, count_nxt;

  assign full      = (count_r == Q_CNT_W'(Q_DEPTH));
  assign not_empty = (count_r != '0);
  assign head_cmd  = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + Q_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + Q_PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + Q_CNT_W'(push) - Q_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

>>> sv/blpg_back.sv
// ----------------------------------------------------------------------------
// blpg_back: Bresenham stepping engine
// Holds the line state, loads it on a start command and on each step command
// of a busy line emits one pixel into the output register and advances the
// cursor and error term.
// ----------------------------------------------------------------------------
module blpg_back import blpg_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cmd_valid,
  input  blpg_cmd_t cmd,
  output logic      cmd_pop,
  output logic      out_valid,
  input  logic      out_stall,
  output coord_t    out_pixel_x,
  output coord_t    out_pixel_y,
  output colour_t   out_pixel_colour,
  output logic      out_last_pixel
);

  logic    busy_r, busy_nxt;
  coord_t  cur_x_r, cur_x_nxt;
  coord_t  cur_y_r, cur_y_nxt;
  err_t    err_r, err_nxt;
  coord_t  major_r, major_nxt;
  coord_t  minor_r, minor_nxt;
  dir_t    dir_x_r, dir_x_nxt;
  dir_t    dir_y_r, dir_y_nxt;
  logic    steep_r, steep_nxt;
  cnt_t    left_r, left_nxt;
  colour_t colour_r, colour_nxt;

  logic    ov_r, ov_nxt;
  coord_t  ox_r, oy_r;
  colour_t oc_r;
  logic    ol_r;
  logic    emit;
  logic    err_neg;
  logic    move_x;
  logic    move_y;
  err_t    two_min;
  err_t    two_maj;

  assign cmd_pop = cmd_valid && (!ov_r || !out_stall);
  assign emit    = cmd_pop && !cmd.is_start && busy_r;
  assign err_neg = err_r[ERR_W-1];
  assign move_x  = steep_r ? !err_neg : 1'b1;
  assign move_y  = steep_r ? 1'b1 : !err_neg;
  assign two_min = $signed({2'b00, minor_r, 1'b0});
  assign two_maj = $signed({2'b00, major_r, 1'b0});

  always_comb begin
    busy_nxt   = busy_r;
    cur_x_nxt  = cur_x_r;
    cur_y_nxt  = cur_y_r;
    err_nxt    = err_r;
    major_nxt  = major_r;
    minor_nxt  = minor_r;
    dir_x_nxt  = dir_x_r;
    dir_y_nxt  = dir_y_r;
    steep_nxt  = steep_r;
    left_nxt   = left_r;
    colour_nxt = colour_r;
    if (cmd_pop && cmd.is_start) begin
      busy_nxt   = (cmd.major != '0);
      cur_x_nxt  = cmd.x;
      cur_y_nxt  = cmd.y;
      err_nxt    = cmd.err;
      major_nxt  = cmd.major;
      minor_nxt  = cmd.minor;
      dir_x_nxt  = cmd.dir_x;
      dir_y_nxt  = cmd.dir_y;
      steep_nxt  = cmd.steep;
      left_nxt   = {1'b0, cmd.major};
      colour_nxt = cmd.colour;
    end else if (emit) begin
      cur_x_nxt = move_x ? move_coord(cur_x_r, dir_x_r) : cur_x_r;
      cur_y_nxt = move_y ? move_coord(cur_y_r, dir_y_r) : cur_y_r;
      err_nxt   = err_r + two_min - (err_neg ? err_t'(0) : two_maj);
      left_nxt  = left_r - cnt_t'(1);
      busy_nxt  = (left_r != cnt_t'(1));
    end
  end

  always_comb begin
    if (cmd_pop) begin
      ov_nxt = emit;
    end else if (!out_stall) begin
      ov_nxt = 1'b0;
    end else begin
      ov_nxt = ov_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_x_r  <= cur_x_nxt;
    cur_y_r  <= cur_y_nxt;
    err_r    <= err_nxt;
    major_r  <= major_nxt;
    minor_r  <= minor_nxt;
    dir_x_r  <= dir_x_nxt;
    dir_y_r  <= dir_y_nxt;
    steep_r  <= steep_nxt;
    left_r   <= left_nxt;
    colour_r <= colour_nxt;
    if (emit) begin
      ox_r <= cur_x_r;
      oy_r <= cur_y_r;
      oc_r <= colour_r;
      ol_r <= (left_r == cnt_t'(1));
    end
  end

  assign out_valid        = ov_r;
  assign out_pixel_x      = ox_r;
  assign out_pixel_y      = oy_r;
  assign out_pixel_colour = oc_r;
  assign out_last_pixel   = ol_r;

endmodule

>>> sv/bresenham_line_pixel_generator.sv
// ----------------------------------------------------------------------------
// bresenham_line_pixel_generator: line draw engine
// A step beat is written into the command queue, then popped by the back end into its output register on out_.
// Throughput: one beat per cycle unless in_stall or out_stall holds the flow.
// The two-entry command queue lets input and output stall independently.
// Reset: synchronous, active low; clears the queue, busy flag and output valid.
// No clearing pass follows reset; the first beat is accepted in the next cycle.
// ----------------------------------------------------------------------------
module bresenham_line_pixel_generator import blpg_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  logic    in_action,
  input  coord_t  in_x_begin,
  input  coord_t  in_y_begin,
  input  coord_t  in_x_finish,
  input  coord_t  in_y_finish,
  input  colour_t in_pen_colour,
  output logic    out_valid,
  input  logic    out_stall,
  output coord_t  out_pixel_x,
  output coord_t  out_pixel_y,
  output colour_t out_pixel_colour,
  output logic    out_last_pixel
);

  blpg_cmd_t front_cmd;
  blpg_cmd_t head_cmd;
  logic      q_full;
  logic      q_not_empty;
  logic      q_pop;
  logic      q_push;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  blpg_front u_front (
    .in_action     (in_action),
    .in_x_begin    (in_x_begin),
    .in_y_begin    (in_y_begin),
    .in_x_finish   (in_x_finish),
    .in_y_finish   (in_y_finish),
    .in_pen_colour (in_pen_colour),
    .cmd           (front_cmd)
  );

  blpg_cmd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (front_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_cmd  (head_cmd)
  );

  blpg_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd_valid        (q_not_empty),
    .cmd              (head_cmd),
    .cmd_pop          (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pixel_x      (out_pixel_x),
    .out_pixel_y      (out_pixel_y),
    .out_pixel_colour (out_pixel_colour),
    .out_last_pixel   (out_last_pixel)
  );

endmodule
